// ===== rtl/atok_pkg.sv =====
package atok_pkg;

  localparam int unsigned MAX_SPACE_RUN_DEF = 255;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned RES_PER_ITEM = 3;

  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_RPAREN = 8'h29;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_USCORE = 8'h5F;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_T  = 8'h74;

  typedef enum logic [2:0] {
    K_NAME, K_ARG, K_SPACES, K_NAME_END, K_ARG_END, K_ATTR_END, K_ERROR, K_DONE
  } kind_t;

  typedef enum logic [2:0] {
    ST_OK, ST_NO_NAME, ST_UNCLOSED, ST_EMPTY_ARG, ST_NO_SEP, ST_NO_COMMA, ST_SPACE_OVF
  } status_t;

  typedef enum logic [3:0] {
    PH_START, PH_NAME, PH_AFTER_NAME, PH_ARGS_OPEN, PH_ARG_START, PH_QUOTED,
    PH_ESCAPE, PH_BARE, PH_AFTER_ARG, PH_AFTER_ATTR, PH_ERROR
  } phase_t;

  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    logic [7:0] count;
    status_t    status;
    logic       last;
  } result_t;

  typedef struct packed {
    logic [1:0]    cnt;
    result_t [2:0] res;
  } bundle_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

  function automatic logic is_head(input logic [7:0] c);
    return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || (c == CH_USCORE);
  endfunction

  function automatic logic is_body(input logic [7:0] c);
    return is_head(c) || (c >= 8'h30 && c <= 8'h39);
  endfunction

  function automatic result_t mk_res(input kind_t k, input logic [7:0] d,
                                     input logic [7:0] n, input status_t s);
    result_t r;
    r.kind   = k;
    r.data   = d;
    r.count  = n;
    r.status = s;
    r.last   = 1'b0;
    return r;
  endfunction

endpackage

// ===== rtl/atok_front.sv =====
module atok_front #(
  parameter int unsigned MAX_SPACE_RUN = atok_pkg::MAX_SPACE_RUN_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_byte,
  input  logic              in_eot,
  input  logic              q_full,
  output logic              push,
  output atok_pkg::bundle_t push_data
);

  localparam int unsigned CW = $clog2(MAX_SPACE_RUN + 1);

  atok_pkg::phase_t  phase_r, phase_nxt;
  logic [CW-1:0]     pend_r, pend_nxt;
  atok_pkg::status_t err_r, err_nxt;

  logic              accept;
  logic [1:0]        n;
  atok_pkg::result_t res [3];
  logic [7:0]        ch;
  logic [CW+7:0]     pend_ext;

  assign in_ready = !q_full;
  assign accept   = in_valid && !q_full;
  assign pend_ext = {8'd0, pend_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= atok_pkg::PH_START;
      pend_r  <= '0;
      err_r   <= atok_pkg::ST_OK;
    end else if (accept) begin
      phase_r <= phase_nxt;
      pend_r  <= pend_nxt;
      err_r   <= err_nxt;
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    pend_nxt  = pend_r;
    err_nxt   = err_r;
    n         = 2'd0;
    ch        = in_byte;
    for (int i = 0; i < 3; i++) begin
      res[i] = atok_pkg::mk_res(atok_pkg::K_NAME, 8'd0, 8'd0, atok_pkg::ST_OK);
    end

    if (in_eot) begin
      case (phase_r)
        atok_pkg::PH_NAME: begin
          res[n] = atok_pkg::mk_res(atok_pkg::K_NAME_END, 8'd0, 8'd0, atok_pkg::ST_OK);
          n = n + 2'd1;
          res[n] = atok_pkg::mk_res(atok_pkg::K_ATTR_END, 8'd0, 8'd0, atok_pkg::ST_OK);
          n = n + 2'd1;
        end
        atok_pkg::PH_AFTER_NAME: begin
          res[n] = atok_pkg::mk_res(atok_pkg::K_ATTR_END, 8'd0, 8'd0, atok_pkg::ST_OK);
          n = n + 2'd1;
        end
        atok_pkg::PH_ARGS_OPEN, atok_pkg::PH_ARG_START: begin
          err_nxt = atok_pkg::ST_EMPTY_ARG;
          res[n] = atok_pkg::mk_res(atok_pkg::K_ERROR, 8'd0, 8'd0, err_nxt);
          n = n + 2'd1;
        end
        atok_pkg::PH_QUOTED, atok_pkg::PH_ESCAPE: begin
          err_nxt = atok_pkg::ST_UNCLOSED;
          res[n] = atok_pkg::mk_res(atok_pkg::K_ERROR, 8'd0, 8'd0, err_nxt);
          n = n + 2'd1;
        end
        atok_pkg::PH_BARE: begin
          res[n] = atok_pkg::mk_res(atok_pkg::K_ARG_END, 8'd0, 8'd0, atok_pkg::ST_OK);
          n = n + 2'd1;
          err_nxt = atok_pkg::ST_NO_SEP;
          res[n] = atok_pkg::mk_res(atok_pkg::K_ERROR, 8'd0, 8'd0, err_nxt);
          n = n + 2'd1;
        end
        atok_pkg::PH_AFTER_ARG: begin
          err_nxt = atok_pkg::ST_NO_SEP;
          res[n] = atok_pkg::mk_res(atok_pkg::K_ERROR, 8'd0, 8'd0, err_nxt);
          n = n + 2'd1;
        end
        default: ;
      endcase
      res[n] = atok_pkg::mk_res(atok_pkg::K_DONE, 8'd0, 8'd0, err_nxt);
      n = n + 2'd1;
      phase_nxt = atok_pkg::PH_START;
      pend_nxt  = '0;
      err_nxt   = atok_pkg::ST_OK;
    end else begin
      case (phase_r)
        atok_pkg::PH_START: begin
          if (!atok_pkg::is_ws(ch)) begin
            if (atok_pkg::is_head(ch)) begin
              res[n] = atok_pkg::mk_res(atok_pkg::K_NAME, ch, 8'd0, atok_pkg::ST_OK);
              n = n + 2'd1;
              phase_nxt = atok_pkg::PH_NAME;
            end else begin
              err_nxt = atok_pkg::ST_NO_NAME;
              phase_nxt = atok_pkg::PH_ERROR;
              pend_nxt = '0;
              res[n] = atok_pkg::mk_res(atok_pkg::K_ERROR, 8'd0, 8'd0, err_nxt);
              n = n + 2'd1;
            end
          end
        end
        atok_pkg::PH_NAME: begin
          if (atok_pkg::is_body(ch)) begin
            res[n] = atok_pkg::mk_res(atok_pkg::K_NAME, ch, 8'd0, atok_pkg::ST_OK);
            n = n + 2'd1;
          end else begin
            res[n] = atok_pkg::mk_res(atok_pkg::K_NAME_END, 8'd0, 8'd0, atok_pkg::ST_OK);
            n = n + 2'd1;
            if (atok_pkg::is_ws(ch)) begin
              phase_nxt = atok_pkg::PH_AFTER_NAME;
            end else if (ch == atok_pkg::CH_LPAREN) begin
              phase_nxt = atok_pkg::PH_ARGS_OPEN;
            end else begin
              res[n] = atok_pkg::mk_res(atok_pkg::K_ATTR_END, 8'd0, 8'd0, atok_pkg::ST_OK);
              n = n + 2'd1;
              if (ch == atok_pkg::CH_COMMA) begin
                phase_nxt = atok_pkg::PH_START;
              end else begin
                err_nxt = atok_pkg::ST_NO_COMMA;
                phase_nxt = atok_pkg::PH_ERROR;
                pend_nxt = '0;
                res[n] = atok_pkg::mk_res(atok_pkg::K_ERROR, 8'd0, 8'd0, err_nxt);
                n = n + 2'd1;
              end
            end
          end
        end
        atok_pkg::PH_AFTER_NAME: begin
          if (!atok_pkg::is_ws(ch)) begin
            if (ch == atok_pkg::CH_LPAREN) begin
              phase_nxt = atok_pkg::PH_ARGS_OPEN;
            end else begin
              res[n] = atok_pkg::mk_res(atok_pkg::K_ATTR_END, 8'd0, 8'd0, atok_pkg::ST_OK);
              n = n + 2'd1;
              if (ch == atok_pkg::CH_COMMA) begin
                phase_nxt = atok_pkg::PH_START;
              end else begin
                err_nxt = atok_pkg::ST_NO_COMMA;
                phase_nxt = atok_pkg::PH_ERROR;
                pend_nxt = '0;
                res[n] = atok_pkg::mk_res(atok_pkg::K_ERROR, 8'd0, 8'd0, err_nxt);
                n = n + 2'd1;
              end
            end
          end
        end
        atok_pkg::PH_ARGS_OPEN, atok_pkg::PH_ARG_START: begin
          if (!atok_pkg::is_ws(ch)) begin
            if (ch == atok_pkg::CH_RPAREN && phase_r == atok_pkg::PH_ARGS_OPEN) begin
              res[n] = atok_pkg::mk_res(atok_pkg::K_ATTR_END, 8'd0, 8'd0, atok_pkg::ST_OK);
              n = n + 2'd1;
              phase_nxt = atok_pkg::PH_AFTER_ATTR;
            end else if (ch == atok_pkg::CH_QUOTE) begin
              phase_nxt = atok_pkg::PH_QUOTED;
            end else if (ch == atok_pkg::CH_COMMA || ch == atok_pkg::CH_RPAREN) begin
              err_nxt = atok_pkg::ST_EMPTY_ARG;
              phase_nxt = atok_pkg::PH_ERROR;
              pend_nxt = '0;
              res[n] = atok_pkg::mk_res(atok_pkg::K_ERROR, 8'd0, 8'd0, err_nxt);
              n = n + 2'd1;
            end else begin
              res[n] = atok_pkg::mk_res(atok_pkg::K_ARG, ch, 8'd0, atok_pkg::ST_OK);
              n = n + 2'd1;
              pend_nxt = '0;
              phase_nxt = atok_pkg::PH_BARE;
            end
          end
        end
        atok_pkg::PH_QUOTED: begin
          if (ch == atok_pkg::CH_QUOTE) begin
            res[n] = atok_pkg::mk_res(atok_pkg::K_ARG_END, 8'd0, 8'd0, atok_pkg::ST_OK);
            n = n + 2'd1;
            phase_nxt = atok_pkg::PH_AFTER_ARG;
          end else if (ch == atok_pkg::CH_BSLASH) begin
            phase_nxt = atok_pkg::PH_ESCAPE;
          end else begin
            res[n] = atok_pkg::mk_res(atok_pkg::K_ARG, ch, 8'd0, atok_pkg::ST_OK);
            n = n + 2'd1;
          end
        end
        atok_pkg::PH_ESCAPE: begin
          if (ch == atok_pkg::CH_LOW_N) begin
            ch = atok_pkg::CH_LF;
          end else if (ch == atok_pkg::CH_LOW_T) begin
            ch = atok_pkg::CH_TAB;
          end
          res[n] = atok_pkg::mk_res(atok_pkg::K_ARG, ch, 8'd0, atok_pkg::ST_OK);
          n = n + 2'd1;
          phase_nxt = atok_pkg::PH_QUOTED;
        end
        atok_pkg::PH_BARE: begin
          if (ch == atok_pkg::CH_COMMA || ch == atok_pkg::CH_RPAREN) begin
            pend_nxt = '0;
            res[n] = atok_pkg::mk_res(atok_pkg::K_ARG_END, 8'd0, 8'd0, atok_pkg::ST_OK);
            n = n + 2'd1;
            if (ch == atok_pkg::CH_COMMA) begin
              phase_nxt = atok_pkg::PH_ARG_START;
            end else begin
              res[n] = atok_pkg::mk_res(atok_pkg::K_ATTR_END, 8'd0, 8'd0, atok_pkg::ST_OK);
              n = n + 2'd1;
              phase_nxt = atok_pkg::PH_AFTER_ATTR;
            end
          end else if (atok_pkg::is_ws(ch)) begin
            if (pend_r >= CW'(MAX_SPACE_RUN)) begin
              err_nxt = atok_pkg::ST_SPACE_OVF;
              phase_nxt = atok_pkg::PH_ERROR;
              pend_nxt = '0;
              res[n] = atok_pkg::mk_res(atok_pkg::K_ERROR, 8'd0, 8'd0, err_nxt);
              n = n + 2'd1;
            end else begin
              pend_nxt = pend_r + 1'b1;
            end
          end else begin
            if (pend_r != '0) begin
              res[n] = atok_pkg::mk_res(atok_pkg::K_SPACES, 8'd0, pend_ext[7:0],
                                        atok_pkg::ST_OK);
              n = n + 2'd1;
              pend_nxt = '0;
            end
            res[n] = atok_pkg::mk_res(atok_pkg::K_ARG, ch, 8'd0, atok_pkg::ST_OK);
            n = n + 2'd1;
          end
        end
        atok_pkg::PH_AFTER_ARG: begin
          if (!atok_pkg::is_ws(ch)) begin
            if (ch == atok_pkg::CH_COMMA) begin
              phase_nxt = atok_pkg::PH_ARG_START;
            end else if (ch == atok_pkg::CH_RPAREN) begin
              res[n] = atok_pkg::mk_res(atok_pkg::K_ATTR_END, 8'd0, 8'd0, atok_pkg::ST_OK);
              n = n + 2'd1;
              phase_nxt = atok_pkg::PH_AFTER_ATTR;
            end else begin
              err_nxt = atok_pkg::ST_NO_SEP;
              phase_nxt = atok_pkg::PH_ERROR;
              pend_nxt = '0;
              res[n] = atok_pkg::mk_res(atok_pkg::K_ERROR, 8'd0, 8'd0, err_nxt);
              n = n + 2'd1;
            end
          end
        end
        atok_pkg::PH_AFTER_ATTR: begin
          if (!atok_pkg::is_ws(ch)) begin
            if (ch == atok_pkg::CH_COMMA) begin
              phase_nxt = atok_pkg::PH_START;
            end else begin
              err_nxt = atok_pkg::ST_NO_COMMA;
              phase_nxt = atok_pkg::PH_ERROR;
              pend_nxt = '0;
              res[n] = atok_pkg::mk_res(atok_pkg::K_ERROR, 8'd0, 8'd0, err_nxt);
              n = n + 2'd1;
            end
          end
        end
        default: ;
      endcase
    end

    // mark the final result of this request
    case (n)
      2'd1:    res[0].last = 1'b1;
      2'd2:    res[1].last = 1'b1;
      2'd3:    res[2].last = 1'b1;
      default: ;
    endcase

    push           = accept && (n != 2'd0);
    push_data.cnt  = n;
    push_data.res  = {res[2], res[1], res[0]};
  end

endmodule

// ===== rtl/atok_queue.sv =====
module atok_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  atok_pkg::bundle_t push_data,
  output logic              full,
  input  logic              pop,
  output logic              empty,
  output atok_pkg::bundle_t head
);

  localparam int unsigned AW = $clog2(atok_pkg::QUEUE_DEPTH);

  atok_pkg::bundle_t slot_r [atok_pkg::QUEUE_DEPTH];
  logic [AW-1:0]     wr_r, wr_nxt;
  logic [AW-1:0]     rd_r, rd_nxt;
  logic [AW:0]       cnt_r, cnt_nxt;

  assign full  = (cnt_r == (AW+1)'(atok_pkg::QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = slot_r[rd_r];

  always_comb begin
    wr_nxt  = push ? AW'(wr_r + 1'b1) : wr_r;
    rd_nxt  = pop ? AW'(rd_r + 1'b1) : rd_r;
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_data;
    end
  end

endmodule

// ===== rtl/atok_back.sv =====
module atok_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  atok_pkg::bundle_t head,
  output logic              pop,
  output logic              out_valid,
  input  logic              out_ready,
  output atok_pkg::result_t out_res
);

  logic              ovalid_r, ovalid_nxt;
  atok_pkg::result_t ores_r, ores_nxt;
  logic [1:0]        idx_r, idx_nxt;
  logic              load;

  assign out_valid = ovalid_r;
  assign out_res   = ores_r;
  assign load      = !ovalid_r || out_ready;

  always_comb begin
    ovalid_nxt = ovalid_r;
    ores_nxt   = ores_r;
    idx_nxt    = idx_r;
    pop        = 1'b0;
    if (load) begin
      ovalid_nxt = !q_empty;
      if (!q_empty) begin
        ores_nxt = head.res[idx_r];
        if (idx_r == head.cnt - 2'd1) begin
          pop     = 1'b1;
          idx_nxt = 2'd0;
        end else begin
          idx_nxt = idx_r + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
      idx_r    <= 2'd0;
    end else begin
      ovalid_r <= ovalid_nxt;
      idx_r    <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ores_r <= ores_nxt;
  end

endmodule

// ===== rtl/attribute_list_tokenizer.sv =====
// Tokenizes a comma-separated attribute list (Name, Name(arg, "quoted", ...)) fed one
// byte per request, with a request flagged by in_tuser marking end of text. A request
// yields zero to three results (name/argument bytes, space runs, end marks, error, done);
// out_tlast flags the last result of each request. The parser front end takes one byte
// per cycle while the queue is not full; the output register sends one result per cycle
// while out_tready is high, so a request with two or three results needs that many output
// transfers, and a four-entry queue between parser and output absorbs such bursts before
// in_tready drops. A result is registered in a queue slot and then in the output register.
// After an error all bytes are dropped until end of text, which returns the block to its
// reset state.
module attribute_list_tokenizer #(
  parameter int unsigned MAX_SPACE_RUN = atok_pkg::MAX_SPACE_RUN_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] text_byte
  input  logic        in_tuser,   // [0] end_of_text
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [7:0] out_byte, [15:8] space_count, [18:16] status
  output logic [2:0]  out_tuser,  // [2:0] kind
  output logic        out_tlast
);

  logic              q_full;
  logic              q_empty;
  logic              push;
  logic              pop;
  atok_pkg::bundle_t push_data;
  atok_pkg::bundle_t head;
  atok_pkg::result_t res;

  atok_front #(
    .MAX_SPACE_RUN(MAX_SPACE_RUN)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_byte   (in_tdata),
    .in_eot    (in_tuser),
    .q_full    (q_full),
    .push      (push),
    .push_data (push_data)
  );

  atok_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (pop),
    .empty     (q_empty),
    .head      (head)
  );

  atok_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_empty),
    .head      (head),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (res)
  );

  assign out_tdata = {5'd0, res.status, res.count, res.data};
  assign out_tuser = res.kind;
  assign out_tlast = res.last;

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
module tb;
  import atok_pkg::*;

  localparam int MAX_RUN = MAX_SPACE_RUN_DEF;
  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 260;

  typedef struct packed {
    logic       eot;
    logic [7:0] ch;
  } text_item_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;
  logic        in_tuser = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  attribute_list_tokenizer dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  text_item_t text_q[$];
  result_t    token_q[$];
  result_t    step_res[$];

  phase_t  tok_phase = PH_START;
  int      tok_spaces = 0;
  status_t tok_err = ST_OK;

  int   errors = 0;
  int   cycles = 0;
  int   fed = 0;
  int   total = 0;
  int   in_gap = 0;
  int   out_gap = 0;
  logic in_fire = 1'b0;
  logic calm = 1'b0;
  int   txt_n = 0;
  int   txt_noise = -1;
  int   txt_cut = -1;

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  function automatic bit blank(logic [7:0] c);
    return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF;
  endfunction

  function automatic bit name_head(logic [7:0] c);
    return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == CH_USCORE;
  endfunction

  function automatic bit name_body(logic [7:0] c);
    return name_head(c) || (c >= "0" && c <= "9");
  endfunction

  function automatic void put(kind_t k, logic [7:0] d, logic [7:0] n, status_t s);
    result_t r;
    r.kind   = k;
    r.data   = d;
    r.count  = n;
    r.status = s;
    r.last   = 1'b0;
    step_res = {step_res, r};
  endfunction

  function automatic void raise_error(status_t s);
    tok_err    = s;
    tok_phase  = PH_ERROR;
    tok_spaces = 0;
    put(K_ERROR, 8'd0, 8'd0, s);
  endfunction

  function automatic void tokenize(logic [7:0] c, logic eot);
    logic [7:0] lit;
    step_res.delete();
    if (eot) begin
      case (tok_phase)
        PH_NAME: begin
          put(K_NAME_END, 8'd0, 8'd0, ST_OK);
          put(K_ATTR_END, 8'd0, 8'd0, ST_OK);
        end
        PH_AFTER_NAME: put(K_ATTR_END, 8'd0, 8'd0, ST_OK);
        PH_ARGS_OPEN, PH_ARG_START: raise_error(ST_EMPTY_ARG);
        PH_QUOTED, PH_ESCAPE: raise_error(ST_UNCLOSED);
        PH_BARE: begin
          put(K_ARG_END, 8'd0, 8'd0, ST_OK);
          raise_error(ST_NO_SEP);
        end
        PH_AFTER_ARG: raise_error(ST_NO_SEP);
        default: ;
      endcase
      put(K_DONE, 8'd0, 8'd0, tok_err);
      tok_phase  = PH_START;
      tok_spaces = 0;
      tok_err    = ST_OK;
    end else begin
      case (tok_phase)
        PH_START: begin
          if (!blank(c)) begin
            if (name_head(c)) begin
              put(K_NAME, c, 8'd0, ST_OK);
              tok_phase = PH_NAME;
            end else begin
              raise_error(ST_NO_NAME);
            end
          end
        end
        PH_NAME: begin
          if (name_body(c)) begin
            put(K_NAME, c, 8'd0, ST_OK);
          end else begin
            put(K_NAME_END, 8'd0, 8'd0, ST_OK);
            if (blank(c)) begin
              tok_phase = PH_AFTER_NAME;
            end else if (c == CH_LPAREN) begin
              tok_phase = PH_ARGS_OPEN;
            end else if (c == CH_COMMA) begin
              put(K_ATTR_END, 8'd0, 8'd0, ST_OK);
              tok_phase = PH_START;
            end else begin
              put(K_ATTR_END, 8'd0, 8'd0, ST_OK);
              raise_error(ST_NO_COMMA);
            end
          end
        end
        PH_AFTER_NAME: begin
          if (!blank(c)) begin
            if (c == CH_LPAREN) begin
              tok_phase = PH_ARGS_OPEN;
            end else begin
              put(K_ATTR_END, 8'd0, 8'd0, ST_OK);
              if (c == CH_COMMA) tok_phase = PH_START;
              else raise_error(ST_NO_COMMA);
            end
          end
        end
        PH_ARGS_OPEN, PH_ARG_START: begin
          if (!blank(c)) begin
            if (c == CH_RPAREN && tok_phase == PH_ARGS_OPEN) begin
              put(K_ATTR_END, 8'd0, 8'd0, ST_OK);
              tok_phase = PH_AFTER_ATTR;
            end else if (c == CH_QUOTE) begin
              tok_phase = PH_QUOTED;
            end else if (c == CH_COMMA || c == CH_RPAREN) begin
              raise_error(ST_EMPTY_ARG);
            end else begin
              put(K_ARG, c, 8'd0, ST_OK);
              tok_spaces = 0;
              tok_phase  = PH_BARE;
            end
          end
        end
        PH_QUOTED: begin
          if (c == CH_QUOTE) begin
            put(K_ARG_END, 8'd0, 8'd0, ST_OK);
            tok_phase = PH_AFTER_ARG;
          end else if (c == CH_BSLASH) begin
            tok_phase = PH_ESCAPE;
          end else begin
            put(K_ARG, c, 8'd0, ST_OK);
          end
        end
        PH_ESCAPE: begin
          lit = c;
          if (c == CH_LOW_N) lit = CH_LF;
          else if (c == CH_LOW_T) lit = CH_TAB;
          put(K_ARG, lit, 8'd0, ST_OK);
          tok_phase = PH_QUOTED;
        end
        PH_BARE: begin
          if (c == CH_COMMA || c == CH_RPAREN) begin
            tok_spaces = 0;
            put(K_ARG_END, 8'd0, 8'd0, ST_OK);
            if (c == CH_COMMA) begin
              tok_phase = PH_ARG_START;
            end else begin
              put(K_ATTR_END, 8'd0, 8'd0, ST_OK);
              tok_phase = PH_AFTER_ATTR;
            end
          end else if (blank(c)) begin
            if (tok_spaces >= MAX_RUN) raise_error(ST_SPACE_OVF);
            else tok_spaces++;
          end else begin
            if (tok_spaces != 0) begin
              put(K_SPACES, 8'd0, tok_spaces[7:0], ST_OK);
              tok_spaces = 0;
            end
            put(K_ARG, c, 8'd0, ST_OK);
          end
        end
        PH_AFTER_ARG: begin
          if (!blank(c)) begin
            if (c == CH_COMMA) begin
              tok_phase = PH_ARG_START;
            end else if (c == CH_RPAREN) begin
              put(K_ATTR_END, 8'd0, 8'd0, ST_OK);
              tok_phase = PH_AFTER_ATTR;
            end else begin
              raise_error(ST_NO_SEP);
            end
          end
        end
        PH_AFTER_ATTR: begin
          if (!blank(c)) begin
            if (c == CH_COMMA) tok_phase = PH_START;
            else raise_error(ST_NO_COMMA);
          end
        end
        default: ;
      endcase
    end
    if (step_res.size() > 0) step_res[step_res.size() - 1].last = 1'b1;
    foreach (step_res[i]) token_q = {token_q, step_res[i]};
  endfunction

  task automatic report(string msg);
    $display("mismatch at cycle %0d: %s", cycles, msg);
    errors++;
  endtask

  function automatic int pick_gap();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  always @(posedge clk) begin
    result_t want;
    if (rst_n) begin
      in_fire <= in_tvalid && in_tready;
      if (in_tvalid && in_tready) begin
        tokenize(in_tdata, in_tuser);
        fed++;
      end
      if (out_tvalid && out_tready) begin
        if (token_q.size() == 0) begin
          report($sformatf("unexpected result kind %0d", out_tuser));
        end else begin
          want = token_q.pop_front();
          if (out_tuser !== want.kind)
            report($sformatf("kind %0d, want %0d", out_tuser, want.kind));
          if (out_tdata[7:0] !== want.data)
            report($sformatf("byte %02h, want %02h", out_tdata[7:0], want.data));
          if (out_tdata[15:8] !== want.count)
            report($sformatf("space count %0d, want %0d", out_tdata[15:8], want.count));
          if (out_tdata[18:16] !== want.status)
            report($sformatf("status %0d, want %0d", out_tdata[18:16], want.status));
          if (out_tlast !== want.last)
            report($sformatf("last %b, want %b", out_tlast, want.last));
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(negedge clk) begin
    if ($urandom_range(0, 399) == 0) calm <= ~calm;
  end

  always @(negedge clk) begin
    text_item_t it;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (!in_tvalid || in_fire) begin
      if (in_gap > 0) begin
        in_tvalid <= 1'b0;
        in_gap    <= in_gap - 1;
      end else if (text_q.size() > 0) begin
        it = text_q.pop_front();
        in_tdata  <= it.ch;
        in_tuser  <= it.eot;
        in_tvalid <= 1'b1;
        in_gap    <= pick_gap();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (out_gap > 0) begin
      out_tready <= 1'b0;
      out_gap    <= out_gap - 1;
    end else begin
      out_tready <= 1'b1;
      if ($urandom_range(0, 99) < 30) out_gap <= pick_gap();
    end
  end

  task automatic push_raw(logic [7:0] c, logic e);
    text_item_t it;
    it.ch  = c;
    it.eot = e;
    text_q = {text_q, it};
  endtask

  task automatic put_char(logic [7:0] c);
    if (txt_cut < 0 || txt_n < txt_cut) begin
      if (txt_n == txt_noise) push_raw(8'($urandom_range(0, 255)), 1'b0);
      else push_raw(c, 1'b0);
    end
    txt_n++;
  endtask

  task automatic put_str(string s);
    foreach (s[i]) put_char(s[i]);
  endtask

  task automatic end_text();
    push_raw(8'($urandom_range(0, 255)), 1'b1);
  endtask

  function automatic logic [7:0] pick_blank();
    case ($urandom_range(0, 5))
      0: return CH_TAB;
      1: return CH_CR;
      2: return CH_LF;
      default: return CH_SPACE;
    endcase
  endfunction

  task automatic put_blanks(int lo, int hi);
    repeat ($urandom_range(lo, hi)) put_char(pick_blank());
  endtask

  function automatic logic [7:0] pick_head();
    int r;
    r = $urandom_range(0, 52);
    if (r < 26) return 8'h41 + r[7:0];
    if (r < 52) return 8'h61 + r[7:0] - 8'd26;
    return CH_USCORE;
  endfunction

  task automatic put_name();
    put_char(pick_head());
    repeat ($urandom_range(0, 4)) begin
      if ($urandom_range(0, 3) == 0) put_char(8'h30 + 8'($urandom_range(0, 9)));
      else put_char(pick_head());
    end
  endtask

  function automatic logic [7:0] bare_char(bit first);
    logic [7:0] c;
    do begin
      c = 8'($urandom_range(0, 255));
    end while (blank(c) || c == CH_COMMA || c == CH_RPAREN || (first && c == CH_QUOTE));
    return c;
  endfunction

  task automatic put_bare(int run);
    put_char(bare_char(1'b1));
    repeat ($urandom_range(0, 3)) begin
      if ($urandom_range(0, 1)) put_blanks(1, 3);
      put_char(bare_char(1'b0));
    end
    if (run > 0) begin
      repeat (run) put_char(pick_blank());
      put_char(bare_char(1'b0));
    end
    if ($urandom_range(0, 1)) put_blanks(1, 2);
  endtask

  task automatic put_quoted();
    logic [7:0] c;
    put_char(CH_QUOTE);
    repeat ($urandom_range(0, 5)) begin
      if ($urandom_range(0, 5) == 0) begin
        put_char(CH_BSLASH);
        case ($urandom_range(0, 3))
          0: put_char(CH_LOW_N);
          1: put_char(CH_LOW_T);
          default: put_char(8'($urandom_range(0, 255)));
        endcase
      end else begin
        do begin
          c = 8'($urandom_range(0, 255));
        end while (c == CH_QUOTE || c == CH_BSLASH);
        put_char(c);
      end
    end
    put_char(CH_QUOTE);
  endtask

  task automatic put_args(int run);
    int n;
    n = $urandom_range(run > 0 ? 1 : 0, 3);
    put_char(CH_LPAREN);
    for (int i = 0; i < n; i++) begin
      put_blanks(0, 1);
      if ((i == 0 && run > 0) || $urandom_range(0, 1)) put_bare(i == 0 ? run : 0);
      else put_quoted();
      put_blanks(0, 1);
      if (i < n - 1) put_char(CH_COMMA);
    end
    put_char(CH_RPAREN);
  endtask

  task automatic gen_text(int run);
    int n_attr;
    int r;
    txt_n     = 0;
    txt_noise = -1;
    txt_cut   = -1;
    if (run == 0) begin
      r = $urandom_range(0, 99);
      if (r < 15) txt_noise = $urandom_range(0, 20);
      else if (r < 27) txt_cut = $urandom_range(0, 20);
    end
    n_attr = $urandom_range(run > 0 ? 1 : 0, 3);
    put_blanks(0, 1);
    for (int i = 0; i < n_attr; i++) begin
      put_name();
      put_blanks(0, 1);
      if ((i == 0 && run > 0) || $urandom_range(0, 2) != 0) put_args(i == 0 ? run : 0);
      put_blanks(0, 1);
      if (i < n_attr - 1 || $urandom_range(0, 3) == 0) put_char(CH_COMMA);
      put_blanks(0, 1);
    end
    end_text();
  endtask

  initial begin
    int stop_at;
    int t;
    end_text();
    put_str("_z9(a b,\"\\n\\t\\q\")");
    end_text();
    put_str("A(x");
    end_text();
    put_str("1");
    end_text();

    stop_at = text_q.size() + RANDOM_ITEMS + 2 * MAX_RUN;
    t = 0;
    while (text_q.size() < stop_at) begin
      gen_text(t == 1 ? MAX_RUN : (t == 4 ? MAX_RUN + 1 : 0));
      t++;
    end
    total = text_q.size();

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (fed < total) @(posedge clk);
    while (token_q.size() > 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
